/* design/assert_macros.svh */
// assertion macros used by the rotation core rtl
// no dependencies; the user scope must provide clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QVR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/qvr_pkg.sv */
// shared constants for the quaternion vector rotation core
// no dependencies
package qvr_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

endpackage

/* design/qvr_if.sv */
// valid/ready channels for the rotation core: sample in, result out
// depends on qvr_pkg
interface qvr_in_if import qvr_pkg::*; #(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] quat_w;
	logic signed [COMP_WIDTH-1:0] quat_x;
	logic signed [COMP_WIDTH-1:0] quat_y;
	logic signed [COMP_WIDTH-1:0] quat_z;
	logic signed [COMP_WIDTH-1:0] vec_x;
	logic signed [COMP_WIDTH-1:0] vec_y;
	logic signed [COMP_WIDTH-1:0] vec_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

interface qvr_out_if import qvr_pkg::*; #(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] rot_x;
	logic signed [COMP_WIDTH-1:0] rot_y;
	logic signed [COMP_WIDTH-1:0] rot_z;
	logic                         saturated;

	modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

/* design/quaternion_vector_rotation_core.sv */
// Rotates a vector by a quaternion, v' = q * (0, v) * conj(q), in exact integer
// arithmetic, then rounds (ties up), drops 2*FRAC_BITS bits and saturates. The work
// runs through five register stages (first products, first sums, second products,
// second sums, round and clip), and one beat is taken every cycle while the result
// side is not stalled. A stall on the result side freezes every stage at once, so
// nothing is lost while ready is low.
// depends on qvr_pkg, qvr_if, qvr_finish and assert_macros.svh
`include "assert_macros.svh"

module quaternion_vector_rotation_core import qvr_pkg::*; #(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	qvr_in_if.sink   sample,
	qvr_out_if.source result
);
	localparam int CW  = COMP_WIDTH;
	localparam int P1W = 2 * CW;
	localparam int AW  = 2 * CW + 2;
	localparam int P2W = AW + CW;
	localparam int RW  = P2W + 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CW-1:0]  q_s1 [4];
	logic signed [CW-1:0]  q_s2 [4];
	logic signed [P1W-1:0] p1_s1 [12];
	logic signed [AW-1:0]  a_s2 [4];
	logic signed [P2W-1:0] p2_s3 [12];
	logic signed [RW-1:0]  r_s4 [3];
	logic signed [CW-1:0]  rot_s5 [3];
	logic                  sat_s5;

	logic signed [CW-1:0] rot_c [3];
	logic [2:0]           clip_c;

	// whole pipe advances when the output slot is free or being taken
	assign en           = !v_s5 || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: products of q and v
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1[0]   <= sample.quat_w;
			q_s1[1]   <= sample.quat_x;
			q_s1[2]   <= sample.quat_y;
			q_s1[3]   <= sample.quat_z;
			p1_s1[0]  <= sample.quat_x * sample.vec_x;
			p1_s1[1]  <= sample.quat_y * sample.vec_y;
			p1_s1[2]  <= sample.quat_z * sample.vec_z;
			p1_s1[3]  <= sample.quat_w * sample.vec_x;
			p1_s1[4]  <= sample.quat_y * sample.vec_z;
			p1_s1[5]  <= sample.quat_z * sample.vec_y;
			p1_s1[6]  <= sample.quat_w * sample.vec_y;
			p1_s1[7]  <= sample.quat_x * sample.vec_z;
			p1_s1[8]  <= sample.quat_z * sample.vec_x;
			p1_s1[9]  <= sample.quat_w * sample.vec_z;
			p1_s1[10] <= sample.quat_x * sample.vec_y;
			p1_s1[11] <= sample.quat_y * sample.vec_x;
		end
	end

	// stage 2: a = q * (0, v)
	always_ff @(posedge clk) begin
		if (en) begin
			q_s2    <= q_s1;
			a_s2[0] <= -(AW'(p1_s1[0]) + AW'(p1_s1[1]) + AW'(p1_s1[2]));
			a_s2[1] <= AW'(p1_s1[3]) + AW'(p1_s1[4]) - AW'(p1_s1[5]);
			a_s2[2] <= AW'(p1_s1[6]) - AW'(p1_s1[7]) + AW'(p1_s1[8]);
			a_s2[3] <= AW'(p1_s1[9]) + AW'(p1_s1[10]) - AW'(p1_s1[11]);
		end
	end

	// stage 3: products of a and q; conjugate signs are applied in the sums
	always_ff @(posedge clk) begin
		if (en) begin
			p2_s3[0]  <= a_s2[1] * q_s2[0];
			p2_s3[1]  <= a_s2[0] * q_s2[1];
			p2_s3[2]  <= a_s2[2] * q_s2[3];
			p2_s3[3]  <= a_s2[3] * q_s2[2];
			p2_s3[4]  <= a_s2[2] * q_s2[0];
			p2_s3[5]  <= a_s2[0] * q_s2[2];
			p2_s3[6]  <= a_s2[1] * q_s2[3];
			p2_s3[7]  <= a_s2[3] * q_s2[1];
			p2_s3[8]  <= a_s2[3] * q_s2[0];
			p2_s3[9]  <= a_s2[0] * q_s2[3];
			p2_s3[10] <= a_s2[1] * q_s2[2];
			p2_s3[11] <= a_s2[2] * q_s2[1];
		end
	end

	// stage 4: vector part of a * conj(q)
	always_ff @(posedge clk) begin
		if (en) begin
			r_s4[0] <= RW'(p2_s3[0]) - RW'(p2_s3[1]) - RW'(p2_s3[2]) + RW'(p2_s3[3]);
			r_s4[1] <= RW'(p2_s3[4]) - RW'(p2_s3[5]) + RW'(p2_s3[6]) - RW'(p2_s3[7]);
			r_s4[2] <= RW'(p2_s3[8]) - RW'(p2_s3[9]) - RW'(p2_s3[10]) + RW'(p2_s3[11]);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_finish
		qvr_finish #(
			.COMP_WIDTH (CW),
			.FRAC_BITS  (FRAC_BITS),
			.ACC_WIDTH  (RW)
		) u_finish (
			.acc     (r_s4[i]),
			.value   (rot_c[i]),
			.clipped (clip_c[i])
		);
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s5 <= rot_c;
			sat_s5 <= |clip_c;
		end
	end

	assign result.valid     = v_s5;
	assign result.rot_x     = rot_s5[0];
	assign result.rot_y     = rot_s5[1];
	assign result.rot_z     = rot_s5[2];
	assign result.saturated = sat_s5;

	localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

	logic            stalled;
	logic            at_bound;
	logic [3*CW:0]   out_word;

	assign stalled  = v_s5 && !result.ready;
	assign out_word = {rot_s5[0], rot_s5[1], rot_s5[2], sat_s5};
	assign at_bound = rot_s5[0] == MAXC || rot_s5[0] == MINC ||
		rot_s5[1] == MAXC || rot_s5[1] == MINC ||
		rot_s5[2] == MAXC || rot_s5[2] == MINC;

	`QVR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result.valid, "result valid in reset")
	`QVR_ASSERT(a_advance, en && v_s4 |=> result.valid, "beat lost between stage 4 and output")
	`QVR_ASSERT(a_stall_hold, stalled |=> v_s5 && $stable(out_word), "output moved while stalled")
	`QVR_ASSERT(a_sat_bound, v_s5 && sat_s5 |-> at_bound, "saturated flag with no clip")
endmodule

/* design/qvr_finish.sv */
// round-to-nearest (ties up), fixed shift and saturation of one rotated component
// depends on qvr_pkg
module qvr_finish import qvr_pkg::*; #(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ACC_WIDTH  = 3 * COMP_WIDTH + 4
) (
	input  logic signed [ACC_WIDTH-1:0]  acc,
	output logic signed [COMP_WIDTH-1:0] value,
	output logic                         clipped
);
	localparam int SH = 2 * FRAC_BITS;
	localparam logic signed [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (SH - 1);
	localparam logic signed [ACC_WIDTH-1:0] MAXV =
		{{(ACC_WIDTH-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] MINV =
		{{(ACC_WIDTH-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};

	logic signed [ACC_WIDTH-1:0] rounded;
	logic signed [ACC_WIDTH-1:0] shifted;

	always_comb begin
		rounded = acc + HALF;
		shifted = rounded >>> SH;
		if (shifted > MAXV) begin
			value   = MAXV[COMP_WIDTH-1:0];
			clipped = 1'b1;
		end else if (shifted < MINV) begin
			value   = MINV[COMP_WIDTH-1:0];
			clipped = 1'b1;
		end else begin
			value   = shifted[COMP_WIDTH-1:0];
			clipped = 1'b0;
		end
	end
endmodule

/* dv/tb_quaternion_vector_rotation_core.sv */
// testbench for quaternion_vector_rotation_core: directed and random samples, checked
// against an exact integer rotation predictor with rounding and clipping
// depends on qvr_pkg, qvr_if and the core rtl
module tb_quaternion_vector_rotation_core import qvr_pkg::*; ();

	localparam int W  = COMP_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint MAXV = (longint'(1) <<< (W - 1)) - 1;
	localparam longint MINV = -(longint'(1) <<< (W - 1));
	localparam logic signed [W-1:0] ONE  = W'(1 << FB);
	localparam logic signed [W-1:0] HALF = W'(1 << (FB - 1));
	// cos(45 deg) in q1.14
	localparam logic signed [W-1:0] C45  = 16'sd11585;

	typedef struct packed {
		logic signed [W-1:0] qw;
		logic signed [W-1:0] qx;
		logic signed [W-1:0] qy;
		logic signed [W-1:0] qz;
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic signed [W-1:0] vz;
	} sample_t;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [W-1:0] z;
		logic                sat;
	} rotated_t;

	logic clk;
	logic arst_n;

	qvr_in_if  #(.COMP_WIDTH(W)) sample_ch ();
	qvr_out_if #(.COMP_WIDTH(W)) result_ch ();

	quaternion_vector_rotation_core #(
		.COMP_WIDTH(W),
		.FRAC_BITS (FB)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	rotated_t pending_rotations[$];
	int       fail_count;
	bit       gaps_on;
	int       hold_req;

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = 1'b1;
			#6 clk = 1'b0;
		end
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// exact q * (0, v) * conj(q), then round half up, drop 2*FB bits, clip
	function automatic rotated_t rotate_by_quat(sample_t s);
		longint w, x, y, z, vx, vy, vz;
		longint aw, ax, ay, az;
		longint acc[3];
		longint r;
		logic signed [W-1:0] comp[3];
		rotated_t res;
		w  = $signed(s.qw);
		x  = $signed(s.qx);
		y  = $signed(s.qy);
		z  = $signed(s.qz);
		vx = $signed(s.vx);
		vy = $signed(s.vy);
		vz = $signed(s.vz);
		aw = -x * vx - y * vy - z * vz;
		ax = w * vx + y * vz - z * vy;
		ay = w * vy - x * vz + z * vx;
		az = w * vz + x * vy - y * vx;
		acc[0] = ax * w - aw * x - ay * z + az * y;
		acc[1] = ay * w - aw * y + ax * z - az * x;
		acc[2] = az * w - aw * z - ax * y + ay * x;
		res.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			r = (acc[i] + (longint'(1) <<< (2 * FB - 1))) >>> (2 * FB);
			if (r > MAXV) begin
				r = MAXV;
				res.sat = 1'b1;
			end else if (r < MINV) begin
				r = MINV;
				res.sat = 1'b1;
			end
			comp[i] = r[W-1:0];
		end
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		return res;
	endfunction

	task automatic drive_sample(input sample_t s);
		while (gaps_on && $urandom_range(99) < 6) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.quat_w <= s.qw;
		sample_ch.quat_x <= s.qx;
		sample_ch.quat_y <= s.qy;
		sample_ch.quat_z <= s.qz;
		sample_ch.vec_x  <= s.vx;
		sample_ch.vec_y  <= s.vy;
		sample_ch.vec_z  <= s.vz;
		do @(posedge clk); while (!sample_ch.ready);
		pending_rotations.push_back(rotate_by_quat(s));
	endtask

	function automatic logic signed [W-1:0] corner_value();
		case ($urandom_range(7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			5: return ONE;
			6: return -ONE;
			default: return W'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int kind;
		logic [127:0] raw;
		kind = $urandom_range(9);
		raw = {$urandom, $urandom, $urandom, $urandom};
		s = raw[$bits(sample_t)-1:0];
		if (kind < 4) begin
			// |q|^2 near or below one, full range vector: mostly unclipped
			s.qw = W'($signed($urandom_range(16384)) - 8192);
			s.qx = W'($signed($urandom_range(16384)) - 8192);
			s.qy = W'($signed($urandom_range(16384)) - 8192);
			s.qz = W'($signed($urandom_range(16384)) - 8192);
		end else if (kind < 6) begin
			s.qw = corner_value();
			s.qx = corner_value();
			s.qy = corner_value();
			s.qz = corner_value();
			s.vx = corner_value();
			s.vy = corner_value();
			s.vz = corner_value();
		end
		return s;
	endfunction

	task automatic test_directed();
		sample_t d[$];
		d.push_back({ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1});
		d.push_back({ONE, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, -16'sd1});
		d.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd32767});
		// quarter turns about each axis
		d.push_back({C45, C45, 16'sd0, 16'sd0, 16'sd1000, 16'sd2000, 16'sd3000});
		d.push_back({C45, 16'sd0, C45, 16'sd0, 16'sd1000, 16'sd2000, 16'sd3000});
		d.push_back({C45, 16'sd0, 16'sd0, C45, 16'sd1000, 16'sd2000, 16'sd3000});
		// half turns
		d.push_back({16'sd0, ONE, 16'sd0, 16'sd0, 16'sd100, -16'sd200, 16'sd300});
		d.push_back({16'sd0, 16'sd0, ONE, 16'sd0, 16'sd100, -16'sd200, 16'sd300});
		d.push_back({16'sd0, 16'sd0, 16'sd0, -ONE, 16'sd100, -16'sd200, 16'sd300});
		d.push_back({HALF, HALF, HALF, HALF, 16'sd32767, -16'sd32768, 16'sd12345});
		// rounding ties: +/-0.5, +/-1.5 and +/-2.5 go toward plus infinity
		d.push_back({W'(1 << (FB - 1)), 16'sd0, 16'sd0, 16'sd0, 16'sd2, -16'sd2, 16'sd6});
		d.push_back({W'(1 << (FB - 1)), 16'sd0, 16'sd0, 16'sd0, -16'sd6, 16'sd10, -16'sd10});
		// mostly non-unit quaternions, which scale and may clip
		d.push_back({16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd8192});
		d.push_back({-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768, -16'sd32768});
		d.push_back({16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 16'sd32767});
		d.push_back({-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
			16'sd32767, -16'sd32768, 16'sd32767});
		d.push_back({16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd32768, 16'sd32767, -16'sd1});
		d.push_back({16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd20000, -16'sd20000, 16'sd100});
		d.push_back({-ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		d.push_back({16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1});
		foreach (d[i])
			drive_sample(d[i]);
	endtask

	task automatic test_random(input int n);
		repeat (n)
			drive_sample(random_sample());
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req = 80;
		repeat (100)
			drive_sample(random_sample());
		gaps_on = 1'b1;
	endtask

	// long stretch of back to back beats on both sides
	task automatic test_streaming();
		gaps_on = 1'b0;
		repeat (200)
			drive_sample(random_sample());
		gaps_on = 1'b1;
	endtask

	initial begin : result_ready
		int hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(99) < 6) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		rotated_t got;
		rotated_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = {result_ch.rot_x, result_ch.rot_y, result_ch.rot_z, result_ch.saturated};
				if (pending_rotations.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result beat x=%0d y=%0d z=%0d sat=%0b",
						$time, got.x, got.y, got.z, got.sat);
				end else begin
					want = pending_rotations.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t mismatch expected %0d %0d %0d %0b got %0d %0d %0d %0b",
							$time, want.x, want.y, want.z, want.sat,
							got.x, got.y, got.z, got.sat);
					end
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		gaps_on = 1'b1;
		hold_req = 0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.quat_w = '0;
		sample_ch.quat_x = '0;
		sample_ch.quat_y = '0;
		sample_ch.quat_z = '0;
		sample_ch.vec_x = '0;
		sample_ch.vec_y = '0;
		sample_ch.vec_z = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(600);
		test_backpressure();
		test_streaming();
		test_random(700);
		sample_ch.valid <= 1'b0;

		while (pending_rotations.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
